// ===== src/dtp_pkg.sv =====
// dtp_pkg: shared types and constants of the disparity reprojection block.
// Used by dtp_front and disparity_to_point.
package dtp_pkg;

    // Image size limit for pixel coordinates
    localparam int unsigned MAX_IMAGE_SIDE = 4096;

    // Quotient bits produced by each divider
    localparam int unsigned DIV_Q = 32;

    // Dividend and divisor widths of the three dividers
    localparam int unsigned ZX_NW = 46;
    localparam int unsigned ZX_DW = 17;
    localparam int unsigned Y_NW  = 66;
    localparam int unsigned Y_DW  = 37;

    // Saturation limits
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAX = 32'h8000_0000;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_FOCAL_X   = 3'd0,
        CFG_FOCAL_Y   = 3'd1,
        CFG_CENTER_X  = 3'd2,
        CFG_CENTER_Y  = 3'd3,
        CFG_BASELINE  = 3'd4,
        CFG_MAX_DISP  = 3'd5
    } cfg_reg_t;

    // Per-pixel data that rides alongside the dividers
    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic        x_neg;
        logic        y_neg;
        logic        y_nodiv;  // focal_y is zero
        logic        y_nz;     // y numerator nonzero
    } side_t;

endpackage

// ===== src/dtp_front.sv =====
// dtp_front: range checks, products and divider operands (three stages).
// Depends on dtp_pkg.
module dtp_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [11:0]                   col,
    input  logic [11:0]                   row,
    input  logic [15:0]                   disparity_raw,
    input  logic [7:0]                    blue_in,
    input  logic [7:0]                    green_in,
    input  logic [7:0]                    red_in,
    input  logic [19:0]                   focal_x,
    input  logic [19:0]                   focal_y,
    input  logic [19:0]                   center_x,
    input  logic [19:0]                   center_y,
    input  logic [23:0]                   stereo_baseline,
    input  logic [15:0]                   max_disparity,
    output logic                          out_valid,
    output dtp_pkg::side_t                out_side,
    output logic [dtp_pkg::ZX_NW-1:0]     z_num,
    output logic [dtp_pkg::ZX_DW-1:0]     z_den,
    output logic [dtp_pkg::ZX_NW-1:0]     x_num,
    output logic [dtp_pkg::ZX_DW-1:0]     x_den,
    output logic [dtp_pkg::Y_NW-1:0]      y_num,
    output logic [dtp_pkg::Y_DW-1:0]      y_den
);

    // Stage 1: checks, F*B, G*D, offsets
    logic            keep;
    logic [19:0]     col_pos;
    logic [19:0]     row_pos;
    logic            s1_vld_reg;
    dtp_pkg::side_t  s1_side_reg;
    logic [43:0]     s1_fb_reg;
    logic [35:0]     s1_gd_reg;
    logic [19:0]     s1_xm_reg;
    logic [19:0]     s1_ym_reg;
    logic [15:0]     s1_d_reg;

    assign col_pos = {col, 8'd0};
    assign row_pos = {row, 8'd0};
    assign keep = (32'(col) < dtp_pkg::MAX_IMAGE_SIDE) && (32'(row) < dtp_pkg::MAX_IMAGE_SIDE)
                  && (disparity_raw != 16'd0) && (disparity_raw < max_disparity);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid && keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg.col     <= col;
            s1_side_reg.row     <= row;
            s1_side_reg.blue    <= blue_in;
            s1_side_reg.green   <= green_in;
            s1_side_reg.red     <= red_in;
            s1_side_reg.x_neg   <= col_pos < center_x;
            s1_side_reg.y_neg   <= row_pos < center_y;
            s1_side_reg.y_nodiv <= focal_y == 20'd0;
            s1_side_reg.y_nz    <= 1'b0;
            s1_xm_reg <= (col_pos >= center_x) ? col_pos - center_x : center_x - col_pos;
            s1_ym_reg <= (row_pos >= center_y) ? row_pos - center_y : center_y - row_pos;
            s1_fb_reg <= focal_x * stereo_baseline;
            s1_gd_reg <= focal_y * disparity_raw;
            s1_d_reg  <= disparity_raw;
        end
    end

    // Stage 2: x numerator and the split y product
    logic            s2_vld_reg;
    dtp_pkg::side_t  s2_side_reg;
    logic [43:0]     s2_fb_reg;
    logic [35:0]     s2_gd_reg;
    logic [15:0]     s2_d_reg;
    logic [43:0]     s2_xb_reg;
    logic [41:0]     s2_yhi_reg;
    logic [41:0]     s2_ylo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_side_reg <= s1_side_reg;
            s2_fb_reg   <= s1_fb_reg;
            s2_gd_reg   <= s1_gd_reg;
            s2_d_reg    <= s1_d_reg;
            s2_xb_reg   <= s1_xm_reg * stereo_baseline;
            s2_yhi_reg  <= s1_ym_reg * s1_fb_reg[43:22];
            s2_ylo_reg  <= s1_ym_reg * s1_fb_reg[21:0];
        end
    end

    // Stage 3: rounding operands, num' = 2*num + den, den' = 2*den
    logic [63:0]    ynum;
    logic           s3_vld_reg;
    dtp_pkg::side_t s3_side;

    assign ynum = {s2_yhi_reg, 22'd0} + 64'(s2_ylo_reg);

    // y numerator flag joins the side data
    always_comb
    begin
        s3_side      = s2_side_reg;
        s3_side.y_nz = ynum != 64'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_side <= s3_side;
            z_num <= {s2_fb_reg, 1'b0} + dtp_pkg::ZX_NW'(s2_d_reg);
            z_den <= {s2_d_reg, 1'b0};
            x_num <= {s2_xb_reg, 1'b0} + dtp_pkg::ZX_NW'(s2_d_reg);
            x_den <= {s2_d_reg, 1'b0};
            y_num <= {1'b0, ynum, 1'b0} + dtp_pkg::Y_NW'(s2_gd_reg);
            y_den <= {s2_gd_reg, 1'b0};
        end
    end

    assign out_valid = s3_vld_reg;

endmodule

// ===== src/dtp_divider.sv =====
// dtp_divider: pipelined restoring divider, one quotient bit per stage.
// Standalone; parameters set dividend, divisor and quotient widths.
module dtp_divider
#(
    parameter int unsigned NW = 46,
    parameter int unsigned DW = 17,
    parameter int unsigned QW = 32
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo,
    output logic          ovf
);

    localparam int unsigned HW = NW - QW;
    localparam int unsigned CW = (HW > DW) ? HW : DW;

    logic [DW-1:0] rem_reg [QW+1];
    logic [QW-1:0] low_reg [QW+1];
    logic [QW-1:0] quo_reg [QW+1];
    logic [DW-1:0] den_reg [QW+1];
    logic          ovf_reg [QW+1];
    logic          ovf_now;

    // Entry stage: quotient overflow check and first partial remainder
    assign ovf_now = CW'(num[NW-1:QW]) >= CW'(den);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf_reg[0] <= ovf_now;
            rem_reg[0] <= ovf_now ? '0 : DW'(num[NW-1:QW]);
            low_reg[0] <= num[QW-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den;
        end
    end

    // One compare and subtract per stage
    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;

        assign trial = {rem_reg[k], low_reg[k][QW-1]};
        assign diff  = trial - {1'b0, den_reg[k]};
        assign ge    = trial >= {1'b0, den_reg[k]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                low_reg[k+1] <= {low_reg[k][QW-2:0], 1'b0};
                quo_reg[k+1] <= {quo_reg[k][QW-2:0], ge};
                den_reg[k+1] <= den_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    assign quo = quo_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule

// ===== src/disparity_to_point.sv =====
// disparity_to_point: stereo disparity to 3-D point, top level.
// Uses dtp_pkg, dtp_front and dtp_divider.
//
// Accepts one pixel per clock and sustains one result per clock. A pixel
// passes from input transfer to result through three front stages
// (checks and products, split y product, rounding operands), 33 divider
// stages (overflow check plus one quotient bit per stage) and the output
// register with saturation. Pixels with zero disparity, disparity at or
// above max_disparity, or coordinates off the image give no result.
// The whole pipeline holds while a result waits on m_tready. Write the
// configuration only while the pipeline is empty.
module disparity_to_point
(
    input  logic          clk,
    input  logic          rst_n,
    // configuration
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [23:0]   cfg_data,
    // pixel in
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,   // col, row, disparity_raw, blue_in, green_in, red_in
    // point out
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [143:0]  m_tdata    // point_x, point_y, point_z, blue_out, green_out,
                                     // red_out, col_out, row_out, zero pad
);

    localparam int unsigned LAT = dtp_pkg::DIV_Q + 1;

    // Configuration registers
    logic [19:0] focal_x_reg;
    logic [19:0] focal_y_reg;
    logic [19:0] center_x_reg;
    logic [19:0] center_y_reg;
    logic [23:0] baseline_reg;
    logic [15:0] max_disp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= 20'd184320;
            focal_y_reg  <= 20'd184320;
            center_x_reg <= 20'd81920;
            center_y_reg <= 20'd61440;
            baseline_reg <= 24'd7864;
            max_disp_reg <= 16'd24576;
        end
        else if (cfg_we)
        begin
            case (dtp_pkg::cfg_reg_t'(cfg_index))
                dtp_pkg::CFG_FOCAL_X:  focal_x_reg  <= cfg_data[19:0];
                dtp_pkg::CFG_FOCAL_Y:  focal_y_reg  <= cfg_data[19:0];
                dtp_pkg::CFG_CENTER_X: center_x_reg <= cfg_data[19:0];
                dtp_pkg::CFG_CENTER_Y: center_y_reg <= cfg_data[19:0];
                dtp_pkg::CFG_BASELINE: baseline_reg <= cfg_data;
                dtp_pkg::CFG_MAX_DISP: max_disp_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Pipeline advance: output register empty or being drained
    logic out_valid_reg;
    logic en;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Front stages
    logic                           f_valid;
    dtp_pkg::side_t                 f_side;
    logic [dtp_pkg::ZX_NW-1:0]      z_num;
    logic [dtp_pkg::ZX_DW-1:0]      z_den;
    logic [dtp_pkg::ZX_NW-1:0]      x_num;
    logic [dtp_pkg::ZX_DW-1:0]      x_den;
    logic [dtp_pkg::Y_NW-1:0]       y_num;
    logic [dtp_pkg::Y_DW-1:0]       y_den;

    dtp_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (s_tvalid),
        .col             (s_tdata[11:0]),
        .row             (s_tdata[23:12]),
        .disparity_raw   (s_tdata[39:24]),
        .blue_in         (s_tdata[47:40]),
        .green_in        (s_tdata[55:48]),
        .red_in          (s_tdata[63:56]),
        .focal_x         (focal_x_reg),
        .focal_y         (focal_y_reg),
        .center_x        (center_x_reg),
        .center_y        (center_y_reg),
        .stereo_baseline (baseline_reg),
        .max_disparity   (max_disp_reg),
        .out_valid       (f_valid),
        .out_side        (f_side),
        .z_num           (z_num),
        .z_den           (z_den),
        .x_num           (x_num),
        .x_den           (x_den),
        .y_num           (y_num),
        .y_den           (y_den)
    );

    // Dividers
    logic [dtp_pkg::DIV_Q-1:0] z_q;
    logic [dtp_pkg::DIV_Q-1:0] x_q;
    logic [dtp_pkg::DIV_Q-1:0] y_q;
    logic                      z_ovf;
    logic                      x_ovf;
    logic                      y_ovf;

    dtp_divider #(.NW(dtp_pkg::ZX_NW), .DW(dtp_pkg::ZX_DW), .QW(dtp_pkg::DIV_Q)) u_div_z
    (
        .clk (clk), .en (en), .num (z_num), .den (z_den), .quo (z_q), .ovf (z_ovf)
    );

    dtp_divider #(.NW(dtp_pkg::ZX_NW), .DW(dtp_pkg::ZX_DW), .QW(dtp_pkg::DIV_Q)) u_div_x
    (
        .clk (clk), .en (en), .num (x_num), .den (x_den), .quo (x_q), .ovf (x_ovf)
    );

    dtp_divider #(.NW(dtp_pkg::Y_NW), .DW(dtp_pkg::Y_DW), .QW(dtp_pkg::DIV_Q)) u_div_y
    (
        .clk (clk), .en (en), .num (y_num), .den (y_den), .quo (y_q), .ovf (y_ovf)
    );

    // Valid and side data delay matching the dividers
    logic           vld_reg  [LAT];
    dtp_pkg::side_t side_reg [LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= f_valid;
            for (int i = 1; i < LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= f_side;
            for (int i = 1; i < LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Saturation
    dtp_pkg::side_t sd;
    logic [31:0]    x_sat;
    logic [31:0]    y_sat;
    logic [30:0]    z_sat;

    assign sd = side_reg[LAT-1];

    always_comb
    begin
        z_sat = (z_ovf || z_q > dtp_pkg::POS_MAX) ? dtp_pkg::POS_MAX[30:0] : z_q[30:0];

        if (!sd.x_neg)
            x_sat = (x_ovf || x_q > dtp_pkg::POS_MAX) ? dtp_pkg::POS_MAX : x_q;
        else
            x_sat = (x_ovf || x_q >= dtp_pkg::NEG_MAX) ? dtp_pkg::NEG_MAX : 32'd0 - x_q;

        if (sd.y_nodiv)
            y_sat = !sd.y_nz ? 32'd0 : (sd.y_neg ? dtp_pkg::NEG_MAX : dtp_pkg::POS_MAX);
        else if (!sd.y_neg)
            y_sat = (y_ovf || y_q > dtp_pkg::POS_MAX) ? dtp_pkg::POS_MAX : y_q;
        else
            y_sat = (y_ovf || y_q >= dtp_pkg::NEG_MAX) ? dtp_pkg::NEG_MAX : 32'd0 - y_q;
    end

    // Output register
    logic [143:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {1'b0, sd.row, sd.col, sd.red, sd.green, sd.blue,
                             z_sat, y_sat, x_sat};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // A point left of the principal column never comes out positive
    a_x_sign: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[LAT-1] && sd.x_neg |=> out_data_reg[31] || out_data_reg[31:0] == 32'd0)
        else $error("point_x positive for a pixel left of center_x");

    // Stalled pipeline keeps the last divider stage occupancy
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg[LAT-1]))
        else $error("pipeline moved during a stall");

    // Zero focal_y with nonzero numerator always saturates y
    a_y_nodiv: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[LAT-1] && sd.y_nodiv && sd.y_nz
        |=> out_data_reg[63:32] == dtp_pkg::POS_MAX || out_data_reg[63:32] == dtp_pkg::NEG_MAX)
        else $error("point_y not saturated with zero focal_y");
`endif

endmodule

// ===== tb/sv/disparity_to_point_check.sv =====
// disparity_to_point_check: watches the pixel, point and register ports of
// disparity_to_point, predicts each point and compares it field by field.
// Depends on dtp_pkg for the register index codes.
`timescale 1ns / 100ps

module disparity_to_point_check
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [23:0]   cfg_data,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [63:0]   s_tdata,   // col, row, disparity_raw, blue, green, red
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [143:0]  m_tdata,   // x, y, z, blue, green, red, col, row, pad
    output int            failures,
    output int            points_waiting,
    output int            points_seen
);

    localparam logic [127:0] SAT_POS = 128'h7FFF_FFFF;
    localparam logic [127:0] SAT_NEG = 128'h8000_0000;

    // camera setup as the block should hold it
    logic [19:0] focal_x, focal_y, center_x, center_y;
    logic [23:0] baseline;
    logic [15:0] max_disp;

    logic [142:0] point_q[$];

    // nearest, ties up
    function automatic logic [127:0] round_quot(logic [127:0] num, logic [127:0] den);
        logic [127:0] q;
        logic [127:0] r;
        q = num / den;
        r = num % den;
        if (2 * r >= den)
            q = q + 1;
        return q;
    endfunction

    function automatic logic [31:0] clamp_signed(logic [127:0] mag, logic neg);
        logic [31:0] m;
        m = mag[31:0];
        if (!neg)
            return (mag > SAT_POS) ? SAT_POS[31:0] : m;
        if (mag >= SAT_NEG)
            return SAT_NEG[31:0];
        return -m;
    endfunction

    // full point word for one pixel, tdata layout without the pad bit
    function automatic logic [142:0] project_point(logic [63:0] px);
        logic [127:0] fb, z, xm, ym, d;
        logic [31:0]  xr, yr;
        logic         xneg, yneg;
        logic [127:0] p;
        d  = px[39:24];
        fb = focal_x * baseline;
        z  = round_quot(fb, d);
        if (z > SAT_POS)
            z = SAT_POS;
        p    = px[11:0] * 256;
        xneg = p < center_x;
        xm   = xneg ? center_x - p : p - center_x;
        xr   = clamp_signed(round_quot(xm * baseline, d), xneg);
        p    = px[23:12] * 256;
        yneg = p < center_y;
        ym   = (yneg ? center_y - p : p - center_y) * fb;
        if (focal_y == 0)
            yr = (ym == 0) ? 32'd0 : clamp_signed(SAT_NEG, yneg);
        else
            yr = clamp_signed(round_quot(ym, focal_y * d), yneg);
        return {px[23:12], px[11:0], px[63:56], px[55:48], px[47:40], z[30:0], yr, xr};
    endfunction

    // register shadow, pixel prediction and point comparison
    always @(posedge clk or negedge rst_n)
    begin
        logic [142:0] want;
        logic [31:0]  ev [8];
        logic [31:0]  av [8];
        string        nm [8];
        int           errs;
        if (!rst_n)
        begin
            focal_x  <= 20'd184320;
            focal_y  <= 20'd184320;
            center_x <= 20'd81920;
            center_y <= 20'd61440;
            baseline <= 24'd7864;
            max_disp <= 16'd24576;
            failures    <= 0;
            points_seen <= 0;
            points_waiting <= 0;
            point_q.delete();
        end
        else
        begin
            errs = 0;
            if (cfg_we)
            begin
                case (cfg_index)
                    dtp_pkg::CFG_FOCAL_X:  focal_x  <= cfg_data[19:0];
                    dtp_pkg::CFG_FOCAL_Y:  focal_y  <= cfg_data[19:0];
                    dtp_pkg::CFG_CENTER_X: center_x <= cfg_data[19:0];
                    dtp_pkg::CFG_CENTER_Y: center_y <= cfg_data[19:0];
                    dtp_pkg::CFG_BASELINE: baseline <= cfg_data;
                    dtp_pkg::CFG_MAX_DISP: max_disp <= cfg_data[15:0];
                    default: ;
                endcase
            end
            // zero or out-of-range disparity gives no point
            if (s_tvalid && s_tready && s_tdata[39:24] != 0 && s_tdata[39:24] < max_disp)
                point_q.insert(point_q.size(), project_point(s_tdata));
            if (m_tvalid && m_tready)
            begin
                points_seen <= points_seen + 1;
                if (point_q.size() == 0)
                begin
                    $display("%0t: unexpected point, expected none, got %h",
                             $realtime, m_tdata);
                    errs++;
                end
                else
                begin
                    want = point_q.pop_front();
                    ev = '{want[31:0], want[63:32], 32'(want[94:64]), 32'(want[102:95]),
                           32'(want[110:103]), 32'(want[118:111]), 32'(want[130:119]),
                           32'(want[142:131])};
                    av = '{m_tdata[31:0], m_tdata[63:32], 32'(m_tdata[94:64]),
                           32'(m_tdata[102:95]), 32'(m_tdata[110:103]),
                           32'(m_tdata[118:111]), 32'(m_tdata[130:119]),
                           32'(m_tdata[142:131])};
                    nm = '{"point_x", "point_y", "point_z", "blue", "green", "red",
                           "col", "row"};
                    for (int i = 0; i < 8; i++)
                        if (ev[i] !== av[i])
                        begin
                            $display("%0t: %s mismatch, expected %h, got %h",
                                     $realtime, nm[i], ev[i], av[i]);
                            errs++;
                        end
                end
            end
            failures       <= failures + errs;
            points_waiting <= point_q.size();
        end
    end

endmodule

// ===== tb/sv/disparity_to_point_test.sv =====
// disparity_to_point_test: clock, reset, register phases and pixel stimulus
// for disparity_to_point; checking is done in disparity_to_point_check.
// Depends on dtp_pkg, disparity_to_point and disparity_to_point_check.
`timescale 1ns / 100ps

module disparity_to_point_test;

    localparam logic [2:0] SPARE_INDEX = 3'd6;
    localparam int         IDLE_LIMIT  = 4000;
    localparam int         DRAIN_WAIT  = 45;

    logic          clk;
    logic          rst_n;
    logic          cfg_we;
    logic [2:0]    cfg_index;
    logic [23:0]   cfg_data;
    logic          s_tvalid;
    logic          s_tready;
    logic [63:0]   s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [143:0]  m_tdata;
    int            failures;
    int            points_waiting;
    int            points_seen;

    logic          pixel_taken, point_taken;
    logic          gaps_on;
    int            idle_cycles;
    int            pixels_sent;
    logic [15:0]   disp_limit;

    disparity_to_point dut (.*);

    disparity_to_point_check checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // transfer flags, read at the following falling edge
    always @(posedge clk)
    begin
        pixel_taken <= s_tvalid && s_tready;
        point_taken <= m_tvalid && m_tready;
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (pixel_taken || point_taken || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("disparity_to_point_test: done, errors");
            $finish;
        end
    end

    // receiver: random stall before each point, none while gaps are off
    initial
    begin
        m_tready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (gaps_on)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(negedge clk); while (!point_taken);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        if (idx == dtp_pkg::CFG_MAX_DISP)
            disp_limit = val[15:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_pixel(logic [11:0] col, logic [11:0] row, logic [15:0] disp);
        int gap;
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), disp, row, col};
        s_tvalid = 1'b1;
        do @(negedge clk); while (!pixel_taken);
        pixels_sent++;
    endtask

    // wait for the pipeline to empty, then the tail where dropped pixels sit
    task automatic drain;
        s_tvalid = 1'b0;
        wait (points_waiting == 0);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic set_camera(logic [19:0] fx, logic [19:0] fy, logic [19:0] cx,
                              logic [19:0] cy, logic [23:0] bl, logic [15:0] md);
        write_reg(dtp_pkg::CFG_FOCAL_X, 24'(fx));
        write_reg(dtp_pkg::CFG_FOCAL_Y, 24'(fy));
        write_reg(dtp_pkg::CFG_CENTER_X, 24'(cx));
        write_reg(dtp_pkg::CFG_CENTER_Y, 24'(cy));
        write_reg(dtp_pkg::CFG_BASELINE, bl);
        write_reg(dtp_pkg::CFG_MAX_DISP, 24'(md));
    endtask

    // mostly valid disparities, some zero or at/above the limit
    task automatic random_pixels(int count);
        int pick;
        logic [15:0] d;
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 19);
            if (pick == 0)
                d = 16'd0;
            else if (pick == 1 || disp_limit <= 1)
                d = 16'($urandom_range(disp_limit, 65535));
            else if (pick == 2)
                d = 16'($urandom_range(1, 3));
            else
                d = 16'($urandom_range(1, disp_limit - 1));
            send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), d);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = dtp_pkg::CFG_FOCAL_X;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        gaps_on    = 1'b1;
        pixels_sent = 0;
        disp_limit = 16'd24576;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset camera: image corners, disparity edges, rejects
        send_pixel(12'd0, 12'd0, 16'd1);
        send_pixel(12'd4095, 12'd4095, 16'd1);
        send_pixel(12'd4095, 12'd0, 16'd24575);
        send_pixel(12'd0, 12'd4095, 16'd24575);
        send_pixel(12'd320, 12'd240, 16'd256);
        send_pixel(12'd100, 12'd200, 16'd0);
        send_pixel(12'd100, 12'd200, 16'd24576);
        send_pixel(12'd100, 12'd200, 16'd65535);
        send_pixel(12'd2048, 12'd1024, 16'd3);
        random_pixels(150);
        // hold off until every point is back
        drain;

        // widest camera, no disparity limit short of the top code
        set_camera(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 24'hFFFFFF, 16'hFFFF);
        write_reg(SPARE_INDEX, 24'h123456);
        send_pixel(12'd0, 12'd0, 16'd1);
        send_pixel(12'd4095, 12'd4095, 16'd65534);
        send_pixel(12'd0, 12'd4095, 16'd65535);
        random_pixels(150);
        drain;

        // smallest camera: zero center and baseline
        set_camera(20'd1, 20'd1, 20'd0, 20'd0, 24'd0, 16'd2);
        send_pixel(12'd4095, 12'd4095, 16'd1);
        send_pixel(12'd0, 12'd0, 16'd1);
        send_pixel(12'd5, 12'd5, 16'd2);
        random_pixels(60);
        drain;

        // zero focal lengths: y and z are zero
        set_camera(20'd0, 20'd0, 20'd81920, 20'd61440, 24'd7864, 16'd24576);
        send_pixel(12'd0, 12'd0, 16'd1);
        send_pixel(12'd320, 12'd240, 16'd100);
        send_pixel(12'd4095, 12'd4095, 16'd100);
        random_pixels(60);
        drain;
        write_reg(dtp_pkg::CFG_FOCAL_X, 24'd184320);
        send_pixel(12'd0, 12'd0, 16'd7);
        send_pixel(12'd4095, 12'd240, 16'd7);
        drain;

        // zero limit rejects every pixel
        write_reg(dtp_pkg::CFG_MAX_DISP, 24'd0);
        random_pixels(30);
        drain;

        // random cameras
        for (int k = 0; k < 5; k++)
        begin
            set_camera(20'($urandom_range(1, 1048575)), 20'($urandom_range(1, 1048575)),
                       20'($urandom_range(0, 1048575)), 20'($urandom_range(0, 1048575)),
                       24'($urandom_range(0, 16777215)), 16'($urandom_range(1, 65535)));
            random_pixels(160);
            drain;
        end

        $display("covered %0d pixels and %0d points over 11 camera setups,",
                 pixels_sent, points_seen);
        $display("including zero focal lengths, zero baseline and register extremes");
        if (failures == 0)
            $display("disparity_to_point_test: done, clean");
        else
            $display("disparity_to_point_test: done, errors");
        $finish;
    end

endmodule

// ===== disparity_to_point.f =====
src/dtp_pkg.sv
src/dtp_front.sv
src/dtp_divider.sv
src/disparity_to_point.sv
tb/sv/disparity_to_point_check.sv
tb/sv/disparity_to_point_test.sv
